/* design/lcdfr_pkg.sv */
// Shared types, constants and helpers for the text LCD frame refresh unit.
`default_nettype none

package lcdfr_pkg;

   // Panel geometry.
   localparam int COLS  = 20;
   localparam int ROWS  = 4;
   localparam int CELLS = COLS * ROWS;

   // Widths: the cursor column runs 0..COLS and the cursor row 0..ROWS.
   localparam int COL_W  = $clog2(COLS + 1);
   localparam int ROW_W  = $clog2(ROWS + 1);
   localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Panel address map.
   localparam int ODD_ROW_OFFSET  = 64;
   localparam int ROW_PAIR_OFFSET = 20;

   // Bytes with a fixed meaning.
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_A         = 8'h41;
   localparam logic [7:0] DISPLAY_ON_CMD = 8'h0C;
   localparam logic [7:0] SET_ADDR_CMD   = 8'h80;

   // Input function codes.
   localparam logic [2:0] FUNC_PUT_CHAR = 3'd0;
   localparam logic [2:0] FUNC_PUT_HEX  = 3'd1;
   localparam logic [2:0] FUNC_RENEW    = 3'd2;
   localparam logic [2:0] FUNC_CURSOR   = 3'd3;
   localparam logic [2:0] FUNC_REFRESH  = 3'd4;

   // Operation kinds handed from the front to the back.
   localparam logic [2:0] KIND_CHAR    = 3'd0;
   localparam logic [2:0] KIND_HEX     = 3'd1;
   localparam logic [2:0] KIND_RENEW   = 3'd2;
   localparam logic [2:0] KIND_CURSOR  = 3'd3;
   localparam logic [2:0] KIND_REFRESH = 3'd4;

   typedef logic [COL_W-1:0]  col_type;
   typedef logic [ROW_W-1:0]  row_type;
   typedef logic [CELL_W-1:0] cell_idx_type;
   typedef logic [QPTR_W-1:0] qptr_type;
   typedef logic [QCNT_W-1:0] qcnt_type;
   typedef logic [6:0]        lcd_addr_type;

   typedef struct packed {
      logic [2:0] func;
      logic [7:0] char_code;
      logic       cursor_visible;
   } req_type;

   typedef struct packed {
      logic       reg_select;
      logic [7:0] bus_byte;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] char_code;
      logic       cursor_visible;
   } op_type;

   // Uppercase hex digit of a nibble.
   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      logic [7:0] wide;
      wide = {4'd0, nib};
      if (nib < 4'd10) begin
         return CHAR_ZERO + wide;
      end
      return CHAR_A + wide - 8'd10;
   endfunction

endpackage

`default_nettype wire

/* design/lcdfr_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module lcdfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 80
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* design/lcdfr_front.sv */
// Front end: accepts input items, classifies them and queues operations.
`default_nettype none

module lcdfr_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire lcdfr_pkg::req_type req_data,
   output logic                   op_valid,
   input  wire logic              op_ready,
   output lcdfr_pkg::op_type      op_data
);

   lcdfr_pkg::op_type   entry_ff [lcdfr_pkg::QUEUE_DEPTH];
   lcdfr_pkg::qptr_type wr_ptr_ff, wr_ptr_in;
   lcdfr_pkg::qptr_type rd_ptr_ff, rd_ptr_in;
   lcdfr_pkg::qcnt_type count_ff, count_in;
   lcdfr_pkg::op_type   op_new;
   logic                known_func;
   logic                push;
   logic                pop;

   // Classify the incoming item; unused function codes never enter the queue.
   always_comb begin
      known_func = 1'b1;
      op_new.char_code = req_data.char_code;
      op_new.cursor_visible = req_data.cursor_visible;
      case (req_data.func)
         lcdfr_pkg::FUNC_PUT_CHAR: op_new.kind = lcdfr_pkg::KIND_CHAR;
         lcdfr_pkg::FUNC_PUT_HEX:  op_new.kind = lcdfr_pkg::KIND_HEX;
         lcdfr_pkg::FUNC_RENEW:    op_new.kind = lcdfr_pkg::KIND_RENEW;
         lcdfr_pkg::FUNC_CURSOR:   op_new.kind = lcdfr_pkg::KIND_CURSOR;
         lcdfr_pkg::FUNC_REFRESH:  op_new.kind = lcdfr_pkg::KIND_REFRESH;
         default: begin
            op_new.kind = lcdfr_pkg::KIND_CHAR;
            known_func = 1'b0;
         end
      endcase
   end

   // Queue handshakes.
   assign req_ready = (count_ff != lcdfr_pkg::qcnt_type'(lcdfr_pkg::QUEUE_DEPTH));
   assign op_valid  = (count_ff != '0);
   assign op_data   = entry_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready && known_func;
   assign pop       = op_valid && op_ready;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == lcdfr_pkg::qptr_type'(lcdfr_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == lcdfr_pkg::qptr_type'(lcdfr_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= op_new;
      end
   end

endmodule

`default_nettype wire

/* design/lcdfr_back.sv */
// Back end: executes queued operations against the frame stores and drives the bus.
`default_nettype none

module lcdfr_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              op_valid,
   output logic                   op_ready,
   input  wire lcdfr_pkg::op_type  op_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output lcdfr_pkg::rsp_type     rsp_data
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_HEX  = 3'd1;
   localparam logic [2:0] ST_READ = 3'd2;
   localparam logic [2:0] ST_ADDR = 3'd3;
   localparam logic [2:0] ST_DATA = 3'd4;

   logic [2:0]                 state_ff, state_in;
   lcdfr_pkg::col_type         cursor_col_ff, cursor_col_in;
   lcdfr_pkg::row_type         cursor_row_ff, cursor_row_in;
   lcdfr_pkg::col_type         scan_x_ff, scan_x_in;
   lcdfr_pkg::row_type         scan_y_ff, scan_y_in;
   logic [lcdfr_pkg::CELLS-1:0] back_valid_ff, back_valid_in;
   logic [lcdfr_pkg::CELLS-1:0] cache_valid_ff, cache_valid_in;
   logic [7:0]                 hex_lo_ff, hex_lo_in;
   lcdfr_pkg::cell_idx_type    cell_ff, cell_in;
   lcdfr_pkg::lcd_addr_type    addr_ff, addr_in;
   logic [7:0]                 value_ff, value_in;
   logic                       back_vbit_ff, back_vbit_in;
   logic                       cache_vbit_ff, cache_vbit_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   lcdfr_pkg::rsp_type         rsp_data_ff, rsp_data_in;

   // Put-char datapath.
   logic                       pc_active;
   logic [7:0]                 pc_char;
   logic                       pc_we;
   lcdfr_pkg::cell_idx_type    pc_addr;
   lcdfr_pkg::col_type         pc_col;
   lcdfr_pkg::row_type         pc_row;

   // Store ports.
   logic                       rd_en;
   lcdfr_pkg::cell_idx_type    scan_cell;
   logic [7:0]                 back_rd;
   logic [7:0]                 cache_rd;
   logic [7:0]                 back_val;
   logic [7:0]                 cache_val;
   logic                       cache_we;
   logic                       out_free;

   lcdfr_ram #(.WIDTH(8), .DEPTH(lcdfr_pkg::CELLS)) u_back_store (
      .clock   (clock),
      .wr_en   (pc_we),
      .wr_addr (pc_addr),
      .wr_data (pc_char),
      .rd_en   (rd_en),
      .rd_addr (scan_cell),
      .rd_data (back_rd)
   );

   lcdfr_ram #(.WIDTH(8), .DEPTH(lcdfr_pkg::CELLS)) u_shown_cache (
      .clock   (clock),
      .wr_en   (cache_we),
      .wr_addr (cell_ff),
      .wr_data (back_val),
      .rd_en   (rd_en),
      .rd_addr (scan_cell),
      .rd_data (cache_rd)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign scan_cell = lcdfr_pkg::cell_idx_type'(int'(scan_y_ff) * lcdfr_pkg::COLS +
                                               int'(scan_x_ff));

   // Back store entries never written since reset or renew, and cache entries never written since reset, read as zero.
   assign back_val  = back_vbit_ff ? back_rd : 8'd0;
   assign cache_val = cache_vbit_ff ? cache_rd : 8'd0;

   // One put-char step at the cursor.
   always_comb begin
      pc_we   = 1'b0;
      pc_col  = cursor_col_ff;
      pc_row  = cursor_row_ff;
      pc_addr = lcdfr_pkg::cell_idx_type'(int'(cursor_row_ff) * lcdfr_pkg::COLS +
                                         int'(cursor_col_ff));
      if (pc_active && (cursor_row_ff < lcdfr_pkg::row_type'(lcdfr_pkg::ROWS))) begin
         if (pc_char == lcdfr_pkg::CHAR_CR) begin
            pc_we = 1'b0;
         end else if (pc_char == lcdfr_pkg::CHAR_LF) begin
            pc_col = '0;
            pc_row = cursor_row_ff + 1'b1;
         end else if (cursor_col_ff < lcdfr_pkg::col_type'(lcdfr_pkg::COLS)) begin
            pc_we  = 1'b1;
            pc_col = cursor_col_ff + 1'b1;
         end
      end
   end

   // Sequencer.
   always_comb begin
      state_in       = state_ff;
      op_ready       = 1'b0;
      pc_active      = 1'b0;
      pc_char        = op_data.char_code;
      rd_en          = 1'b0;
      cache_we       = 1'b0;
      cursor_col_in  = cursor_col_ff;
      cursor_row_in  = cursor_row_ff;
      scan_x_in      = scan_x_ff;
      scan_y_in      = scan_y_ff;
      back_valid_in  = back_valid_ff;
      cache_valid_in = cache_valid_ff;
      hex_lo_in      = hex_lo_ff;
      cell_in        = cell_ff;
      addr_in        = addr_ff;
      value_in       = value_ff;
      back_vbit_in   = back_vbit_ff;
      cache_vbit_in  = cache_vbit_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (op_valid) begin
               case (op_data.kind)
                  lcdfr_pkg::KIND_CHAR: begin
                     op_ready  = 1'b1;
                     pc_active = 1'b1;
                  end
                  lcdfr_pkg::KIND_HEX: begin
                     op_ready  = 1'b1;
                     pc_active = 1'b1;
                     pc_char   = lcdfr_pkg::hex_digit(op_data.char_code[7:4]);
                     hex_lo_in = lcdfr_pkg::hex_digit(op_data.char_code[3:0]);
                     state_in  = ST_HEX;
                  end
                  lcdfr_pkg::KIND_RENEW: begin
                     if (out_free) begin
                        op_ready      = 1'b1;
                        back_valid_in = '0;
                        cursor_col_in = '0;
                        cursor_row_in = '0;
                        rsp_valid_in  = 1'b1;
                        rsp_data_in   = '{reg_select: 1'b0,
                                          bus_byte: lcdfr_pkg::DISPLAY_ON_CMD,
                                          last: 1'b1};
                     end
                  end
                  lcdfr_pkg::KIND_CURSOR: begin
                     if (out_free) begin
                        op_ready     = 1'b1;
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '{reg_select: 1'b0,
                                         bus_byte: lcdfr_pkg::DISPLAY_ON_CMD |
                                                   {6'd0, op_data.cursor_visible, 1'b0},
                                         last: 1'b1};
                     end
                  end
                  lcdfr_pkg::KIND_REFRESH: begin
                     // Read both stores at the scan cell and advance the scan.
                     op_ready      = 1'b1;
                     rd_en         = 1'b1;
                     cell_in       = scan_cell;
                     back_vbit_in  = back_valid_ff[scan_cell];
                     cache_vbit_in = cache_valid_ff[scan_cell];
                     addr_in       = lcdfr_pkg::lcd_addr_type'(int'(scan_x_ff) +
                                     int'(scan_y_ff % 2) * lcdfr_pkg::ODD_ROW_OFFSET +
                                     int'(scan_y_ff / 2) * lcdfr_pkg::ROW_PAIR_OFFSET);
                     if (scan_x_ff == lcdfr_pkg::col_type'(lcdfr_pkg::COLS - 1)) begin
                        scan_x_in = '0;
                        scan_y_in = (scan_y_ff == lcdfr_pkg::row_type'(lcdfr_pkg::ROWS - 1)) ?
                                    '0 : scan_y_ff + 1'b1;
                     end else begin
                        scan_x_in = scan_x_ff + 1'b1;
                     end
                     state_in = ST_READ;
                  end
                  default: begin
                     op_ready = 1'b1;
                  end
               endcase
            end
         end
         ST_HEX: begin
            pc_active = 1'b1;
            pc_char   = hex_lo_ff;
            state_in  = ST_IDLE;
         end
         ST_READ: begin
            // Store data is back; a changed cell updates the cache and goes out.
            if (back_val != cache_val) begin
               cache_we                = 1'b1;
               cache_valid_in[cell_ff] = 1'b1;
               value_in                = back_val;
               state_in                = ST_ADDR;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_ADDR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{reg_select: 1'b0,
                                bus_byte: lcdfr_pkg::SET_ADDR_CMD | {1'b0, addr_ff},
                                last: 1'b0};
               state_in     = ST_DATA;
            end
         end
         ST_DATA: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{reg_select: 1'b1,
                                bus_byte: (value_ff == 8'd0) ? lcdfr_pkg::CHAR_SPACE : value_ff,
                                last: 1'b1};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Put-char updates of the cursor and the back store valid bits.
      if (pc_active) begin
         cursor_col_in = pc_col;
         cursor_row_in = pc_row;
         if (pc_we) begin
            back_valid_in[pc_addr] = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cursor_col_ff  <= '0;
         cursor_row_ff  <= '0;
         scan_x_ff      <= '0;
         scan_y_ff      <= '0;
         back_valid_ff  <= '0;
         cache_valid_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cursor_col_ff  <= cursor_col_in;
         cursor_row_ff  <= cursor_row_in;
         scan_x_ff      <= scan_x_in;
         scan_y_ff      <= scan_y_in;
         back_valid_ff  <= back_valid_in;
         cache_valid_ff <= cache_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      hex_lo_ff     <= hex_lo_in;
      cell_ff       <= cell_in;
      addr_ff       <= addr_in;
      value_ff      <= value_in;
      back_vbit_ff  <= back_vbit_in;
      cache_vbit_ff <= cache_vbit_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule

`default_nettype wire

/* design/text_lcd_frame_refresh_unit.sv */
// Top level of the text LCD frame refresh unit.
// This unit keeps a composed text frame and a cache of what the panel shows, and turns
// put-char, put-hex, renew, cursor and refresh-step items into controller bytes. Items
// enter a two-entry queue and are then executed one at a time by the back end: a put
// hex writes its high digit and then its low digit, and a refresh step first reads the
// frame stores through their registered read port and, for a changed cell, then sends
// the address byte and the data byte in turn through the single output register.
// Result bytes wait in that output register until taken, so a stalled bus holds the back
// end whenever it has a byte to send; the queue accepts items until full. Both stores
// clear at reset via per-cell valid bits: no clearing pass, and items are taken at once.
`default_nettype none

module text_lcd_frame_refresh_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire lcdfr_pkg::req_type req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output lcdfr_pkg::rsp_type      rsp_data
);

   logic              op_valid;
   logic              op_ready;
   lcdfr_pkg::op_type op_data;

   // Accept and classify.
   lcdfr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .op_valid  (op_valid),
      .op_ready  (op_ready),
      .op_data   (op_data)
   );

   // Execute and drive the bus.
   lcdfr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (op_valid),
      .op_ready  (op_ready),
      .op_data   (op_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
